### src/wfo_pkg.sv
// Package for the wavetable FM oscillator: item types, codes, wave table functions.
`timescale 1ns / 1ps

package wfo_pkg;

   // Sizes of the design.
   localparam int TABLE_SIZE        = 1024;
   localparam int TBL_W             = $clog2(TABLE_SIZE);
   localparam int QUARTER           = TABLE_SIZE / 4;
   localparam int QUARTER_W         = $clog2(QUARTER);
   localparam int VOICE_COUNT_DEF   = 16;
   localparam int CMD_DEPTH         = 2;
   localparam int RSP_DEPTH         = 4;
   localparam int CREDIT_W          = $clog2(RSP_DEPTH + 1);
   localparam int CSR_IDX_W         = 2;
   localparam int CSR_DATA_W        = 16;

   // Operation codes of an input item.
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_STOP  = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_WAVE_SHAPE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_GAIN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_RATIO  = 2'd2;

   // Wave shape codes.
   localparam logic [1:0] SHAPE_SINE     = 2'd0;
   localparam logic [1:0] SHAPE_SAW      = 2'd1;
   localparam logic [1:0] SHAPE_SQUARE   = 2'd2;
   localparam logic [1:0] SHAPE_TRIANGLE = 2'd3;

   // Register reset values.
   localparam logic [1:0]  WAVE_SHAPE_RST  = SHAPE_SINE;
   localparam logic [15:0] OUTPUT_GAIN_RST = 16'd32768;
   localparam logic [15:0] SYNC_RATIO_RST  = 16'd256;

   // Odd polynomial for sin(t * pi/2), Q1.30 coefficients.
   localparam longint unsigned SIN_C1  = 64'd1686629713;
   localparam longint unsigned SIN_C3  = 64'd693598678;
   localparam longint unsigned SIN_C5  = 64'd85569307;
   localparam longint unsigned SIN_C7  = 64'd5027001;
   localparam longint unsigned SIN_C9  = 64'd172272;
   localparam longint unsigned SIN_C11 = 64'd3864;

   typedef struct packed {
      logic [1:0]         op;
      logic [3:0]         voice;
      logic [31:0]        phase_step;
      logic signed [15:0] mod_sum;
   } req_type;

   typedef struct packed {
      logic [3:0]         voice_out;
      logic signed [15:0] sample;
   } rsp_type;

   // Classified command handed from the front to the engine.
   typedef struct packed {
      logic [1:0]         op;
      logic [3:0]         voice;
      logic               in_range;
      logic [31:0]        phase_step;
      logic signed [32:0] msync;      // (mod_sum + 1.0) * sync_ratio, Q12.20 scale
   } cmd_type;

   // Updated voice phase handed from the engine to the sample pipeline.
   typedef struct packed {
      logic [3:0]  voice;
      logic        in_range;
      logic [31:0] phase;
   } smp_type;

   typedef enum logic {
      ENG_FETCH,
      ENG_UPDATE
   } eng_state_type;

   typedef logic [14:0] sine_rom_type [0:QUARTER];

   // Quarter-wave sine magnitudes in Q1.15, including the peak at the quarter turn.
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type    rom;
      longint unsigned t;
      longint unsigned u;
      longint unsigned p;
      longint unsigned q;
      for (int k = 0; k <= QUARTER; k++) begin
         t = longint'(k) << (30 - QUARTER_W);
         u = (t * t) >> 30;
         p = SIN_C11;
         p = SIN_C9 - ((p * u) >> 30);
         p = SIN_C7 - ((p * u) >> 30);
         p = SIN_C5 - ((p * u) >> 30);
         p = SIN_C3 - ((p * u) >> 30);
         p = SIN_C1 - ((p * u) >> 30);
         q = (((p * t) >> 30) + 64'd16384) >> 15;
         if (q > 64'd32767) begin
            q = 64'd32767;
         end
         rom[k] = q[14:0];
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

   // One wave table entry in Q1.15 for the given shape and index.
   function automatic logic signed [15:0] wave_entry(logic [1:0] shape, logic [TBL_W-1:0] i);
      logic [QUARTER_W:0]  k;
      logic [QUARTER_W:0]  kk;
      logic signed [15:0]  mag;
      logic signed [TBL_W+8:0] v;
      logic signed [TBL_W+8:0] t;
      logic signed [15:0]  res;
      k   = {1'b0, i[QUARTER_W-1:0]};
      kk  = i[TBL_W-2] ? (QUARTER_W+1)'(QUARTER) - k : k;
      mag = $signed({1'b0, SINE_ROM[kk]});
      v   = $signed({2'b00, i, 7'd0});
      t   = v;
      res = '0;
      case (shape)
         SHAPE_SINE: begin
            res = i[TBL_W-1] ? -mag : mag;
         end
         SHAPE_SAW: begin
            res = {~i[TBL_W-1], i[TBL_W-2:0], (16 - TBL_W)'(0)};
         end
         SHAPE_SQUARE: begin
            res = i[TBL_W-1] ? -16'sd32767 : 16'sd32767;
         end
         default: begin
            if (i[TBL_W-1:TBL_W-2] == 2'b00) begin
               t = v;
            end else if (i[TBL_W-1:TBL_W-2] == 2'b11) begin
               t = v - (TBL_W+9)'(131072);
            end else begin
               t = (TBL_W+9)'(65536) - v;
            end
            if (t > (TBL_W+9)'(32767)) begin
               res = 16'sd32767;
            end else if (t < -(TBL_W+9)'(32768)) begin
               res = -16'sd32768;
            end else begin
               res = t[15:0];
            end
         end
      endcase
      return res;
   endfunction

endpackage

### src/wavetable_fm_oscillator.sv
// Top level of the multi-voice wavetable FM oscillator.
`timescale 1ns / 1ps

// Channel   Ports                           Direction  Moves
// request   push, full, req_item            in         one item: op, voice, step, modulation
// response  empty, pop, rsp_item            out        one item: voice and scaled sample
// config    csr_wr_en, csr_index, csr_wdata in         one register write, no wait
//
// Each accepted item gives exactly one response item, in order. The engine handles each
// item in a fetch state (multiply) and an update state (read-modify-write of voice phase
// and step), so it takes no new item before it is through with the last one. Reset is
// synchronous and active high and clears all voices, both queues and the registers (sine,
// unity gain, ratio one). At most four issued items await a pop, so the response queue
// never overflows; full rises once the command queue fills.

module wavetable_fm_oscillator #(
   parameter int VOICE_COUNT = wfo_pkg::VOICE_COUNT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   output logic                             full,
   input  wfo_pkg::req_type                 req_item,
   output logic                             empty,
   input  logic                             pop,
   output wfo_pkg::rsp_type                 rsp_item,
   input  logic                             csr_wr_en,
   input  logic [wfo_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [wfo_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   // Configuration registers.
   logic [1:0]  wave_shape_ff;
   logic [1:0]  wave_shape_in;
   logic [15:0] output_gain_ff;
   logic [15:0] output_gain_in;
   logic [15:0] sync_ratio_ff;
   logic [15:0] sync_ratio_in;

   // Front to command queue to engine.
   wfo_pkg::cmd_type cmd_wr;
   wfo_pkg::cmd_type cmd_rd;
   logic             cmd_push;
   logic             cmd_pop;
   logic             cmd_full;
   logic             cmd_empty;

   // Engine to sample pipeline to response queue.
   logic             smp_valid;
   wfo_pkg::smp_type smp;
   logic             rsp_valid;
   wfo_pkg::rsp_type rsp_wr;
   logic             rsp_full;
   logic             rsp_take;

   // Writes to an index past the last register are dropped.
   always_comb begin
      wave_shape_in  = wave_shape_ff;
      output_gain_in = output_gain_ff;
      sync_ratio_in  = sync_ratio_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            wfo_pkg::CSR_WAVE_SHAPE: begin
               wave_shape_in = csr_wdata[1:0];
            end
            wfo_pkg::CSR_OUTPUT_GAIN: begin
               output_gain_in = csr_wdata;
            end
            wfo_pkg::CSR_SYNC_RATIO: begin
               sync_ratio_in = csr_wdata;
            end
            default: begin
               wave_shape_in = wave_shape_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_shape_ff  <= wfo_pkg::WAVE_SHAPE_RST;
         output_gain_ff <= wfo_pkg::OUTPUT_GAIN_RST;
         sync_ratio_ff  <= wfo_pkg::SYNC_RATIO_RST;
      end else begin
         wave_shape_ff  <= wave_shape_in;
         output_gain_ff <= output_gain_in;
         sync_ratio_ff  <= sync_ratio_in;
      end
   end

   // The front classifies the item and forms the modulation factor in the accept cycle.
   wfo_front #(
      .VOICE_COUNT (VOICE_COUNT)
   ) u_front (
      .push       (push),
      .full       (full),
      .req_item   (req_item),
      .sync_ratio (sync_ratio_ff),
      .cmd_full   (cmd_full),
      .cmd_push   (cmd_push),
      .cmd        (cmd_wr)
   );

   wfo_fifo #(
      .WIDTH ($bits(wfo_pkg::cmd_type)),
      .DEPTH (wfo_pkg::CMD_DEPTH)
   ) u_cmd_queue (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .din   (cmd_wr),
      .pop   (cmd_pop),
      .dout  (cmd_rd),
      .full  (cmd_full),
      .empty (cmd_empty)
   );

   // The engine owns the voice state; its credit count tracks items not yet popped.
   wfo_engine #(
      .VOICE_COUNT (VOICE_COUNT)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd       (cmd_rd),
      .cmd_pop   (cmd_pop),
      .rsp_take  (rsp_take),
      .smp_valid (smp_valid),
      .smp       (smp)
   );

   wfo_sample u_sample (
      .clock       (clock),
      .reset       (reset),
      .smp_valid   (smp_valid),
      .smp         (smp),
      .wave_shape  (wave_shape_ff),
      .output_gain (output_gain_ff),
      .rsp_valid   (rsp_valid),
      .rsp         (rsp_wr)
   );

   // Credits guarantee space here, so rsp_full never blocks a write in practice.
   wfo_fifo #(
      .WIDTH ($bits(wfo_pkg::rsp_type)),
      .DEPTH (wfo_pkg::RSP_DEPTH)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (rsp_valid & ~rsp_full),
      .din   (rsp_wr),
      .pop   (pop),
      .dout  (rsp_item),
      .full  (rsp_full),
      .empty (empty)
   );

   assign rsp_take = pop & ~empty;

endmodule

### src/wfo_fifo.sv
// Small first-in first-out queue of flip-flops used between the oscillator stages.
`timescale 1ns / 1ps

module wfo_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             full,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff;
   logic [PW-1:0]    wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff;
   logic [PW-1:0]    rd_ptr_in;
   logic [CW-1:0]    count_ff;
   logic [CW-1:0]    count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign dout    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      count_in = count_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

### src/wfo_front.sv
// Front end: accepts items, checks the voice range and forms the modulation factor.
`timescale 1ns / 1ps

module wfo_front #(
   parameter int VOICE_COUNT = wfo_pkg::VOICE_COUNT_DEF
) (
   input  logic              push,
   output logic              full,
   input  wfo_pkg::req_type  req_item,
   input  logic [15:0]       sync_ratio,
   input  logic              cmd_full,
   output logic              cmd_push,
   output wfo_pkg::cmd_type  cmd
);

   logic signed [16:0] mod_one;
   logic signed [33:0] msync_full;

   // mod_sum + 1.0 in Q4.12, then times the Q8.8 ratio.
   assign mod_one    = 17'(req_item.mod_sum) + 17'sd4096;
   assign msync_full = mod_one * $signed({1'b0, sync_ratio});

   assign full     = cmd_full;
   assign cmd_push = push & ~cmd_full;

   always_comb begin
      cmd.op         = req_item.op;
      cmd.voice      = req_item.voice;
      cmd.in_range   = (32'(req_item.voice) < VOICE_COUNT);
      cmd.phase_step = req_item.phase_step;
      cmd.msync      = $signed(msync_full[32:0]);
   end

endmodule

### src/wfo_engine.sv
// Voice engine: holds phase and step per voice and applies each command in a fetch and an update state.
`timescale 1ns / 1ps

module wfo_engine #(
   parameter int VOICE_COUNT = wfo_pkg::VOICE_COUNT_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_empty,
   input  wfo_pkg::cmd_type cmd,
   output logic             cmd_pop,
   input  logic             rsp_take,
   output logic             smp_valid,
   output wfo_pkg::smp_type smp
);

   localparam int VIDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

   wfo_pkg::eng_state_type state_ff;
   wfo_pkg::eng_state_type state_in;

   logic [31:0]       phase_ff [VOICE_COUNT];
   logic [31:0]       step_ff  [VOICE_COUNT];
   logic [31:0]       phase_in;
   logic [31:0]       step_in;

   wfo_pkg::cmd_type  cmd_ff;
   logic [31:0]       prod_ff;
   logic signed [65:0] prod_full;
   logic [31:0]       step_rd;
   logic [31:0]       phase_rd;
   logic [VIDX_W-1:0] head_idx;
   logic [VIDX_W-1:0] cur_idx;
   logic              issue;

   logic [wfo_pkg::CREDIT_W-1:0] credit_ff;
   logic [wfo_pkg::CREDIT_W-1:0] credit_in;

   logic             smp_valid_ff;
   logic             smp_valid_in;
   wfo_pkg::smp_type smp_ff;
   wfo_pkg::smp_type smp_in;

   assign head_idx = VIDX_W'(cmd.voice);
   assign cur_idx  = VIDX_W'(cmd_ff.voice);
   assign step_rd  = cmd.in_range ? step_ff[head_idx] : '0;
   assign phase_rd = cmd_ff.in_range ? phase_ff[cur_idx] : '0;

   // Only bits 51..20 of the signed product matter, the phase is modulo one.
   assign prod_full = $signed(cmd.msync) * $signed({1'b0, step_rd});

   assign credit_in = credit_ff + wfo_pkg::CREDIT_W'(issue)
                      - wfo_pkg::CREDIT_W'(rsp_take);

   always_comb begin
      state_in = state_ff;
      issue    = 1'b0;
      unique case (state_ff)
         wfo_pkg::ENG_FETCH: begin
            if (!cmd_empty && (credit_ff < wfo_pkg::CREDIT_W'(wfo_pkg::RSP_DEPTH))) begin
               issue    = 1'b1;
               state_in = wfo_pkg::ENG_UPDATE;
            end
         end
         wfo_pkg::ENG_UPDATE: begin
            state_in = wfo_pkg::ENG_FETCH;
         end
         default: begin
            state_in = wfo_pkg::ENG_FETCH;
         end
      endcase
   end

   assign cmd_pop = issue;

   always_comb begin
      phase_in = phase_rd;
      step_in  = cmd_ff.in_range ? step_ff[cur_idx] : '0;
      unique case (cmd_ff.op)
         wfo_pkg::OP_TICK: begin
            phase_in = phase_rd + prod_ff;
         end
         wfo_pkg::OP_START: begin
            step_in = cmd_ff.phase_step;
         end
         wfo_pkg::OP_STOP: begin
            phase_in = '0;
            step_in  = '0;
         end
         default: begin
            phase_in = phase_rd;
         end
      endcase
      if (!cmd_ff.in_range) begin
         phase_in = '0;
      end
      smp_valid_in    = (state_ff == wfo_pkg::ENG_UPDATE);
      smp_in.voice    = cmd_ff.voice;
      smp_in.in_range = cmd_ff.in_range;
      smp_in.phase    = phase_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wfo_pkg::ENG_FETCH;
         credit_ff    <= '0;
         smp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         credit_ff    <= credit_in;
         smp_valid_ff <= smp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int v = 0; v < VOICE_COUNT; v++) begin
            phase_ff[v] <= '0;
            step_ff[v]  <= '0;
         end
      end else if ((state_ff == wfo_pkg::ENG_UPDATE) && cmd_ff.in_range) begin
         phase_ff[cur_idx] <= phase_in;
         step_ff[cur_idx]  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         cmd_ff  <= cmd;
         prod_ff <= prod_full[51:20];
      end
      if (smp_valid_in) begin
         smp_ff <= smp_in;
      end
   end

   assign smp_valid = smp_valid_ff;
   assign smp       = smp_ff;

endmodule

### src/wfo_sample.sv
// Sample pipeline: table lookup, linear interpolation, gain and saturation.
`timescale 1ns / 1ps

module wfo_sample (
   input  logic             clock,
   input  logic             reset,
   input  logic             smp_valid,
   input  wfo_pkg::smp_type smp,
   input  logic [1:0]       wave_shape,
   input  logic [15:0]      output_gain,
   output logic             rsp_valid,
   output wfo_pkg::rsp_type rsp
);

   localparam int TBL_W = wfo_pkg::TBL_W;

   logic [TBL_W-1:0]   idx_a;
   logic [TBL_W-1:0]   idx_b;
   logic [15:0]        frac;
   logic signed [15:0] ent_a;
   logic signed [15:0] ent_b;

   logic               s0_valid_ff;
   logic [3:0]         s0_voice_ff;
   logic               s0_range_ff;
   logic signed [15:0] s0_a_ff;
   logic signed [15:0] s0_b_ff;
   logic [15:0]        s0_frac_ff;

   logic signed [16:0] diff;
   logic signed [32:0] lerp_prod;

   logic               s1_valid_ff;
   logic [3:0]         s1_voice_ff;
   logic               s1_range_ff;
   logic signed [15:0] s1_a_ff;
   logic signed [32:0] s1_prod_ff;

   logic signed [16:0] lerp_sum;
   logic signed [15:0] lerp_val;
   logic signed [32:0] gain_prod;

   logic               s2_valid_ff;
   logic [3:0]         s2_voice_ff;
   logic               s2_range_ff;
   logic signed [32:0] s2_prod_ff;

   logic signed [17:0] scaled;
   logic signed [15:0] clamped;

   // The two neighboring table entries are looked up and registered first.
   assign idx_a = smp.phase[31 -: TBL_W];
   assign idx_b = idx_a + TBL_W'(1);
   assign frac  = smp.phase[31-TBL_W -: 16];
   assign ent_a = wfo_pkg::wave_entry(wave_shape, idx_a);
   assign ent_b = wfo_pkg::wave_entry(wave_shape, idx_b);

   assign diff      = 17'(s0_b_ff) - 17'(s0_a_ff);
   assign lerp_prod = diff * $signed({1'b0, s0_frac_ff});

   // Bits 32..16 of the product are the floored quotient by 65536.
   assign lerp_sum  = 17'(s1_a_ff) + $signed(s1_prod_ff[32:16]);
   assign lerp_val  = lerp_sum[15:0];
   assign gain_prod = lerp_val * $signed({1'b0, output_gain});

   assign scaled = $signed(s2_prod_ff[32:15]);

   always_comb begin
      if (scaled > 18'sd32767) begin
         clamped = 16'sd32767;
      end else if (scaled < -18'sd32768) begin
         clamped = -16'sd32768;
      end else begin
         clamped = scaled[15:0];
      end
      rsp.voice_out = s2_voice_ff;
      rsp.sample    = s2_range_ff ? clamped : '0;
   end

   assign rsp_valid = s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= smp_valid;
         s1_valid_ff <= s0_valid_ff;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s0_voice_ff <= smp.voice;
      s0_range_ff <= smp.in_range;
      s0_a_ff     <= ent_a;
      s0_b_ff     <= ent_b;
      s0_frac_ff  <= frac;
      s1_voice_ff <= s0_voice_ff;
      s1_range_ff <= s0_range_ff;
      s1_a_ff     <= s0_a_ff;
      s1_prod_ff  <= lerp_prod;
      s2_voice_ff <= s1_voice_ff;
      s2_range_ff <= s1_range_ff;
      s2_prod_ff  <= gain_prod;
   end

endmodule
